// File: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL. Every user supplies clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent checked at the same clock edge
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked at the clock edge after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/bptc_pkg.sv
`timescale 1ns / 1ps

package bptc_pkg;

    // Field and coefficient widths
    localparam int RAW_W    = 24;
    localparam int COEFF_W  = 16;
    localparam int OUT_W    = 32;
    localparam int IN_TDATA_W  = 2 * RAW_W;
    localparam int OUT_TDATA_W = 2 * OUT_W;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SENS_BASE   = 3'd0,
        REG_OFFSET_BASE = 3'd1,
        REG_SENS_TEMP   = 3'd2,
        REG_OFFSET_TEMP = 3'd3,
        REG_REF_TEMP    = 3'd4,
        REG_TEMP_SLOPE  = 3'd5
    } cfg_reg_t;

    // Pipeline depth
    localparam int NUM_STAGES = 9;

    // Internal datapath widths, sized from the worst-case magnitudes
    localparam int DT_W     = 25;   // D2 - C5*256
    localparam int TEMP_W   = 20;   // temperature in centi-degrees
    localparam int WIDE_W   = 42;   // offset / sensitivity and their products
    localparam int PDD_W    = 50;   // dT squared
    localparam int T2_W     = 18;   // dT^2 >> 31
    localparam int SQR_W    = 40;   // raw square of a temperature delta
    localparam int SQ_W     = 36;   // square kept after range trim
    localparam int SENS_SPLIT = 20; // low slice of SENS for the split multiply
    localparam int PHI_W    = 47;   // D1 * SENS high slice
    localparam int PLO_W    = 44;   // D1 * SENS low slice
    localparam int FULL_W   = 68;   // full D1 * SENS
    localparam int PSH_W    = 47;   // D1 * SENS >> 21
    localparam int DIFF_W   = 48;   // before the final shift

    // Shifts
    localparam int TEMP_SHIFT       = 23;
    localparam int OFF_BASE_SHIFT   = 17;
    localparam int SENS_BASE_SHIFT  = 16;
    localparam int OFF_DT_SHIFT     = 6;
    localparam int SENS_DT_SHIFT    = 7;
    localparam int REF_TEMP_SHIFT   = 8;
    localparam int T2_SHIFT         = 31;
    localparam int OFF2_SHIFT       = 4;
    localparam int PRESS_SENS_SHIFT = 21;
    localparam int PRESS_OUT_SHIFT  = 15;

    // Second-order correction factors
    localparam int OFF2_FACTOR       = 61;
    localparam int OFF2_VLOW_FACTOR  = 15;
    localparam int SENS2_FACTOR      = 2;
    localparam int SENS2_VLOW_FACTOR = 8;

    // Temperature thresholds in centi-degrees
    localparam logic signed [TEMP_W-1:0] TEMP_REF_CENTI  = 20'sd2000;
    localparam logic signed [TEMP_W-1:0] TEMP_VLOW_CENTI = -20'sd1500;

endpackage

// File: hw/rtl/baro_pressure_temp_compensation_core.sv
`timescale 1ns / 1ps
// Barometric second-order compensation core.
// Input stream (s_axis_*): one transaction carries a raw pressure count and a
// raw temperature count. Output stream (m_axis_*): one transaction per input
// with the compensated temperature (0.01 C) and pressure (0.01 mbar), both
// two's complement.
// Calibration words C1..C6 are written through cfg_we / cfg_index / cfg_wdata
// (index 0..5, other indexes ignored); the user must write them only while no
// transaction is in flight; the block itself does not enforce this. The
// pipeline has nine register stages and takes one sample per cycle unless it
// is full and the receiver stalls it; the stages are dT, the four dT products,
// first-order terms, delta squares, correction terms, correction apply, split
// D1*SENS multiply, product sum, and the final subtract and shift.
// Reset clears all stage valid bits and sets the calibration words to zero.
// When the receiver holds m_axis_tready low the output stage holds its
// transaction; upstream stages keep filling bubbles, and s_axis_tready drops
// only once every stage holds a sample.
`include "assert_macros.svh"

module baro_pressure_temp_compensation_core
    import bptc_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write port
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COEFF_W-1:0]     cfg_wdata,
    // Sample input
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // raw_pressure[23:0], raw_temperature[47:24]
    // Compensated output
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // temperature_centi[31:0], pressure_centi_mbar[63:32]
);

    // Calibration registers
    logic [COEFF_W-1:0] sens_base_coeff_reg;
    logic [COEFF_W-1:0] offset_base_coeff_reg;
    logic [COEFF_W-1:0] sens_temp_coeff_reg;
    logic [COEFF_W-1:0] offset_temp_coeff_reg;
    logic [COEFF_W-1:0] ref_temp_coeff_reg;
    logic [COEFF_W-1:0] temp_slope_coeff_reg;

    // Pipeline control
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_en;

    // Stage 0: dT
    logic [RAW_W-1:0]         d1_0_reg;
    logic signed [DT_W-1:0]   dt_0_reg, dt_0_next;
    // Stage 1: products of dT
    logic [RAW_W-1:0]         d1_1_reg;
    logic signed [WIDE_W-1:0] pt_1_reg, pt_1_next;
    logic signed [WIDE_W-1:0] poff_1_reg, poff_1_next;
    logic signed [WIDE_W-1:0] psens_1_reg, psens_1_next;
    logic signed [PDD_W-1:0]  pdd_1_reg, pdd_1_next;
    // Stage 2: first-order terms
    logic [RAW_W-1:0]         d1_2_reg;
    logic signed [TEMP_W-1:0] temp_2_reg, temp_2_next;
    logic signed [WIDE_W-1:0] off1_2_reg, off1_2_next;
    logic signed [WIDE_W-1:0] sens1_2_reg, sens1_2_next;
    logic [T2_W-1:0]          t2_2_reg, t2_2_next;
    // Stage 3: squared temperature deltas
    logic [RAW_W-1:0]         d1_3_reg;
    logic signed [TEMP_W-1:0] temp_3_reg;
    logic signed [WIDE_W-1:0] off1_3_reg;
    logic signed [WIDE_W-1:0] sens1_3_reg;
    logic [T2_W-1:0]          t2_3_reg;
    logic [SQ_W-1:0]          tl2_3_reg, tl2_3_next;
    logic [SQ_W-1:0]          tv2_3_reg, tv2_3_next;
    logic                     low_3_reg, low_3_next;
    logic                     vlow_3_reg, vlow_3_next;
    // Stage 4: correction terms
    logic [RAW_W-1:0]         d1_4_reg;
    logic signed [TEMP_W-1:0] temp_4_reg;
    logic signed [WIDE_W-1:0] off1_4_reg;
    logic signed [WIDE_W-1:0] sens1_4_reg;
    logic [T2_W-1:0]          t2_4_reg;
    logic                     low_4_reg;
    logic [WIDE_W-1:0]        off2_4_reg, off2_4_next;
    logic [WIDE_W-1:0]        sens2_4_reg, sens2_4_next;
    // Stage 5: corrected values
    logic [RAW_W-1:0]         d1_5_reg;
    logic signed [TEMP_W-1:0] tempf_5_reg, tempf_5_next;
    logic signed [WIDE_W-1:0] off_5_reg, off_5_next;
    logic signed [WIDE_W-1:0] sens_5_reg, sens_5_next;
    // Stage 6: split D1 * SENS
    logic signed [TEMP_W-1:0] tempf_6_reg;
    logic signed [WIDE_W-1:0] off_6_reg;
    logic signed [PHI_W-1:0]  phi_6_reg, phi_6_next;
    logic [PLO_W-1:0]         plo_6_reg, plo_6_next;
    // Stage 7: product sum and shift
    logic signed [TEMP_W-1:0] tempf_7_reg;
    logic signed [WIDE_W-1:0] off_7_reg;
    logic signed [PSH_W-1:0]  psh_7_reg, psh_7_next;
    // Stage 8: output register
    logic [OUT_W-1:0]         tempf_8_reg, tempf_8_next;
    logic [OUT_W-1:0]         pres_8_reg, pres_8_next;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sens_base_coeff_reg   <= '0;
            offset_base_coeff_reg <= '0;
            sens_temp_coeff_reg   <= '0;
            offset_temp_coeff_reg <= '0;
            ref_temp_coeff_reg    <= '0;
            temp_slope_coeff_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SENS_BASE:   sens_base_coeff_reg   <= cfg_wdata;
                REG_OFFSET_BASE: offset_base_coeff_reg <= cfg_wdata;
                REG_SENS_TEMP:   sens_temp_coeff_reg   <= cfg_wdata;
                REG_OFFSET_TEMP: offset_temp_coeff_reg <= cfg_wdata;
                REG_REF_TEMP:    ref_temp_coeff_reg    <= cfg_wdata;
                REG_TEMP_SLOPE:  temp_slope_coeff_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Stage enables: a stage loads when empty or when the next one loads
    always_comb
    begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
        valid_next[0] = stage_en[0] ? s_axis_tvalid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            valid_next[i] = stage_en[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stage 0: temperature difference
    always_comb
    begin
        dt_0_next = $signed({1'b0, s_axis_tdata[IN_TDATA_W-1:RAW_W]})
                  - $signed({1'b0, ref_temp_coeff_reg, {REF_TEMP_SHIFT{1'b0}}});
    end

    // Stage 1: four multiplies by dT
    always_comb
    begin
        pt_1_next    = dt_0_reg * $signed({1'b0, temp_slope_coeff_reg});
        poff_1_next  = dt_0_reg * $signed({1'b0, offset_temp_coeff_reg});
        psens_1_next = dt_0_reg * $signed({1'b0, sens_temp_coeff_reg});
        pdd_1_next   = dt_0_reg * dt_0_reg;
    end

    // Stage 2: first-order temperature, offset, sensitivity and T2
    always_comb
    begin
        temp_2_next  = TEMP_W'(pt_1_reg >>> TEMP_SHIFT) + TEMP_REF_CENTI;
        off1_2_next  = WIDE_W'({offset_base_coeff_reg, {OFF_BASE_SHIFT{1'b0}}})
                     + WIDE_W'(poff_1_reg >>> OFF_DT_SHIFT);
        sens1_2_next = WIDE_W'({sens_base_coeff_reg, {SENS_BASE_SHIFT{1'b0}}})
                     + WIDE_W'(psens_1_reg >>> SENS_DT_SHIFT);
        t2_2_next    = T2_W'(pdd_1_reg >>> T2_SHIFT);
    end

    // Stage 3: squares of the distance below the two thresholds
    always_comb
    begin
        logic signed [TEMP_W-1:0] tl;
        logic signed [TEMP_W-1:0] tv;
        logic signed [SQR_W-1:0]  sq_tl;
        logic signed [SQR_W-1:0]  sq_tv;
        tl          = temp_2_reg - TEMP_REF_CENTI;
        tv          = temp_2_reg - TEMP_VLOW_CENTI;
        sq_tl       = tl * tl;
        sq_tv       = tv * tv;
        tl2_3_next  = SQ_W'(sq_tl);
        tv2_3_next  = SQ_W'(sq_tv);
        low_3_next  = temp_2_reg < TEMP_REF_CENTI;
        vlow_3_next = temp_2_reg < TEMP_VLOW_CENTI;
    end

    // Stage 4: OFF2 and SENS2, constant multiplies only
    always_comb
    begin
        logic [WIDE_W-1:0] tl2_w;
        logic [WIDE_W-1:0] tv2_w;
        logic [WIDE_W-1:0] off2_lo;
        tl2_w   = WIDE_W'(tl2_3_reg);
        tv2_w   = WIDE_W'(tv2_3_reg);
        off2_lo = (tl2_w * WIDE_W'(OFF2_FACTOR)) >> OFF2_SHIFT;
        if (vlow_3_reg)
        begin
            off2_4_next  = off2_lo + tv2_w * WIDE_W'(OFF2_VLOW_FACTOR);
            sens2_4_next = tl2_w * WIDE_W'(SENS2_FACTOR)
                         + tv2_w * WIDE_W'(SENS2_VLOW_FACTOR);
        end
        else
        begin
            off2_4_next  = off2_lo;
            sens2_4_next = tl2_w * WIDE_W'(SENS2_FACTOR);
        end
    end

    // Stage 5: apply the low-temperature corrections
    always_comb
    begin
        if (low_4_reg)
        begin
            tempf_5_next = temp_4_reg - TEMP_W'(t2_4_reg);
            off_5_next   = off1_4_reg - off2_4_reg;
            sens_5_next  = sens1_4_reg - sens2_4_reg;
        end
        else
        begin
            tempf_5_next = temp_4_reg;
            off_5_next   = off1_4_reg;
            sens_5_next  = sens1_4_reg;
        end
    end

    // Stage 6: D1 * SENS as two partial products
    always_comb
    begin
        phi_6_next = $signed({1'b0, d1_5_reg}) * $signed(sens_5_reg[WIDE_W-1:SENS_SPLIT]);
        plo_6_next = d1_5_reg * sens_5_reg[SENS_SPLIT-1:0];
    end

    // Stage 7: combine partial products, scale by 2^-21
    always_comb
    begin
        logic signed [FULL_W-1:0] full;
        full       = ($signed(FULL_W'(phi_6_reg)) <<< SENS_SPLIT)
                   + $signed(FULL_W'(plo_6_reg));
        psh_7_next = PSH_W'(full >>> PRESS_SENS_SHIFT);
    end

    // Stage 8: subtract offset, final scale
    always_comb
    begin
        logic signed [DIFF_W-1:0] diff;
        diff         = DIFF_W'(psh_7_reg) - DIFF_W'(off_7_reg);
        pres_8_next  = OUT_W'(diff >>> PRESS_OUT_SHIFT);
        tempf_8_next = OUT_W'(tempf_7_reg);
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (stage_en[0])
        begin
            d1_0_reg <= s_axis_tdata[RAW_W-1:0];
            dt_0_reg <= dt_0_next;
        end
        if (stage_en[1])
        begin
            d1_1_reg    <= d1_0_reg;
            pt_1_reg    <= pt_1_next;
            poff_1_reg  <= poff_1_next;
            psens_1_reg <= psens_1_next;
            pdd_1_reg   <= pdd_1_next;
        end
        if (stage_en[2])
        begin
            d1_2_reg    <= d1_1_reg;
            temp_2_reg  <= temp_2_next;
            off1_2_reg  <= off1_2_next;
            sens1_2_reg <= sens1_2_next;
            t2_2_reg    <= t2_2_next;
        end
        if (stage_en[3])
        begin
            d1_3_reg    <= d1_2_reg;
            temp_3_reg  <= temp_2_reg;
            off1_3_reg  <= off1_2_reg;
            sens1_3_reg <= sens1_2_reg;
            t2_3_reg    <= t2_2_reg;
            tl2_3_reg   <= tl2_3_next;
            tv2_3_reg   <= tv2_3_next;
            low_3_reg   <= low_3_next;
            vlow_3_reg  <= vlow_3_next;
        end
        if (stage_en[4])
        begin
            d1_4_reg    <= d1_3_reg;
            temp_4_reg  <= temp_3_reg;
            off1_4_reg  <= off1_3_reg;
            sens1_4_reg <= sens1_3_reg;
            t2_4_reg    <= t2_3_reg;
            low_4_reg   <= low_3_reg;
            off2_4_reg  <= off2_4_next;
            sens2_4_reg <= sens2_4_next;
        end
        if (stage_en[5])
        begin
            d1_5_reg    <= d1_4_reg;
            tempf_5_reg <= tempf_5_next;
            off_5_reg   <= off_5_next;
            sens_5_reg  <= sens_5_next;
        end
        if (stage_en[6])
        begin
            tempf_6_reg <= tempf_5_reg;
            off_6_reg   <= off_5_reg;
            phi_6_reg   <= phi_6_next;
            plo_6_reg   <= plo_6_next;
        end
        if (stage_en[7])
        begin
            tempf_7_reg <= tempf_6_reg;
            off_7_reg   <= off_6_reg;
            psh_7_reg   <= psh_7_next;
        end
        if (stage_en[8])
        begin
            tempf_8_reg <= tempf_8_next;
            pres_8_reg  <= pres_8_next;
        end
    end

    // Ports
    assign s_axis_tready = stage_en[0];
    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {pres_8_reg, tempf_8_reg};

    // Checks
    `ASSERT_NEXT(a_first_stage_holds, valid_reg[0] && !stage_en[1], valid_reg[0],
        "blocked sample lost from first stage")
    `ASSERT_SAME(a_full_stall_blocks_input, (&valid_reg) && !m_axis_tready, !s_axis_tready,
        "input accepted while pipeline full and stalled")
    `ASSERT_SAME(a_out_from_pipe, $rose(m_axis_tvalid), $past(valid_reg[NUM_STAGES-2]),
        "output valid without a sample in the stage before")
    `ASSERT_NEXT(a_low_temp_below_ref, stage_en[5] && valid_reg[4] && low_4_reg,
        tempf_5_reg < TEMP_REF_CENTI, "corrected low temperature not below reference")

endmodule

// File: tb/baro_pressure_temp_compensation_core_tb.sv
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_core_tb
    import bptc_pkg::*;
;

    localparam int CLK_HALF    = 5;
    localparam int LATENCY     = NUM_STAGES;
    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 120;
    localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
    localparam logic [COEFF_W-1:0] COEFF_MAX = {COEFF_W{1'b1}};

    // Indexes past the last calibration word; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

    // One expected compensated sample, with the raw pair kept for messages
    typedef struct {
        logic [RAW_W-1:0]        raw_p;
        logic [RAW_W-1:0]        raw_t;
        logic signed [OUT_W-1:0] temp_out;
        logic signed [OUT_W-1:0] press_centi;
    } comp_sample_t;

    // Compensation predictor and result checker
    class comp_scoreboard;
        localparam longint T_REF   = 2000;
        localparam longint T_VLOW  = -1500;
        localparam int SH_TEMP     = 23;
        localparam int SH_OFF_BASE = 17;
        localparam int SH_SENS_BASE = 16;
        localparam int SH_OFF_DT   = 6;
        localparam int SH_SENS_DT  = 7;
        localparam int SH_REF      = 8;
        localparam int SH_T2       = 31;
        localparam int SH_OFF2     = 4;
        localparam int SH_P_SENS   = 21;
        localparam int SH_P_OUT    = 15;

        logic [COEFF_W-1:0] calib [6];
        comp_sample_t       outstanding [$];
        int errors;
        int checked;
        int cold_hits;
        int very_cold_hits;
        int settings;

        function new();
            foreach (calib[i]) calib[i] = '0;
            errors = 0;
            checked = 0;
            cold_hits = 0;
            very_cold_hits = 0;
            settings = 1;
        endfunction

        // Mirror a calibration write; unknown indexes are dropped like in the block
        function void write_coeff(int idx, logic [COEFF_W-1:0] val);
            if (idx >= REG_SENS_BASE && idx <= REG_TEMP_SLOPE)
                calib[idx] = val;
        endfunction

        function int pending();
            return outstanding.size();
        endfunction

        // Work out the compensated pair for an accepted sample
        function void note_sample(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
            longint d1, d2, c1, c2, c3, c4, c5, c6;
            longint dt, temp, off, sens, t2, tl, tl2, off2, sens2, tv, tv2, press;
            comp_sample_t s;
            d1 = raw_p;
            d2 = raw_t;
            c1 = calib[REG_SENS_BASE];
            c2 = calib[REG_OFFSET_BASE];
            c3 = calib[REG_SENS_TEMP];
            c4 = calib[REG_OFFSET_TEMP];
            c5 = calib[REG_REF_TEMP];
            c6 = calib[REG_TEMP_SLOPE];

            // first order
            dt   = d2 - (c5 <<< SH_REF);
            temp = T_REF + ((dt * c6) >>> SH_TEMP);
            off  = (c2 <<< SH_OFF_BASE) + ((c4 * dt) >>> SH_OFF_DT);
            sens = (c1 <<< SH_SENS_BASE) + ((c3 * dt) >>> SH_SENS_DT);

            // second order, cold and very cold
            if (temp < T_REF) begin
                cold_hits++;
                t2    = (dt * dt) >>> SH_T2;
                tl    = temp - T_REF;
                tl2   = tl * tl;
                off2  = (61 * tl2) >>> SH_OFF2;
                sens2 = 2 * tl2;
                if (temp < T_VLOW) begin
                    very_cold_hits++;
                    tv    = temp - T_VLOW;
                    tv2   = tv * tv;
                    off2  = off2 + 15 * tv2;
                    sens2 = sens2 + 8 * tv2;
                end
                temp = temp - t2;
                off  = off - off2;
                sens = sens - sens2;
            end

            press = (((d1 * sens) >>> SH_P_SENS) - off) >>> SH_P_OUT;

            s.raw_p       = raw_p;
            s.raw_t       = raw_t;
            s.temp_out    = temp[OUT_W-1:0];
            s.press_centi = press[OUT_W-1:0];
            outstanding.push_back(s);
        endfunction

        task report(string what);
            $display("ERROR @%0t: %s", $realtime, what);
            errors++;
        endtask

        // Compare one output transaction with the oldest expectation
        task check_result(logic [OUT_TDATA_W-1:0] tdata);
            comp_sample_t s;
            logic signed [OUT_W-1:0] got_t, got_p;
            got_t = tdata[OUT_W-1:0];
            got_p = tdata[2*OUT_W-1:OUT_W];
            if (outstanding.size() == 0) begin
                report($sformatf("output T=%0d P=%0d with no sample outstanding",
                                 got_t, got_p));
                return;
            end
            s = outstanding.pop_front();
            checked++;
            if (got_t !== s.temp_out)
                report($sformatf("D1=%0d D2=%0d temperature %0d, expected %0d",
                                 s.raw_p, s.raw_t, got_t, s.temp_out));
            if (got_p !== s.press_centi)
                report($sformatf("D1=%0d D2=%0d pressure %0d, expected %0d",
                                 s.raw_p, s.raw_t, got_p, s.press_centi));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = REG_SENS_BASE;
    logic [COEFF_W-1:0]     cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;     // raw_pressure[23:0], raw_temperature[47:24]
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;          // temperature_centi[31:0], pressure_centi_mbar[63:32]

    comp_scoreboard     sb = new();
    logic [COEFF_W-1:0] next_calib [6];
    bit                 steady = 1'b0;       // no idling on either side
    bit                 long_hold_req = 1'b0;
    int                 cycle_count = 0;

    baro_pressure_temp_compensation_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d samples outstanding",
                     cycle_count, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady)
            return 0;
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: check every output transaction, then pick next tready
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
            if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD - 1;
                m_axis_tready <= 1'b0;
            end
            else if (steady || $urandom_range(0, 99) < 65)
                m_axis_tready <= 1'b1;
            else
            begin
                stall_left = pick_gap();
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Raw temperature at a signed distance from the reference, clamped to 24 bits
    function automatic logic [RAW_W-1:0] raw_near_ref(int delta);
        int v;
        v = int'(next_calib[REG_REF_TEMP]) * 256 + delta;
        if (v < 0)
            return '0;
        if (v > int'(RAW_MAX))
            return RAW_MAX;
        return RAW_W'(v);
    endfunction

    // Write all six calibration words, optionally plus a dropped write
    task automatic load_calib(bit spare);
        for (int r = REG_SENS_BASE; r <= REG_TEMP_SLOPE; r++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(r);
            cfg_wdata <= next_calib[r];
            @(posedge clk);
            sb.write_coeff(r, next_calib[r]);
        end
        if (spare)
        begin
            cfg_index <= CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_LO, CFG_IDX_SPARE_HI));
            cfg_wdata <= COEFF_W'($urandom);
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.settings++;
    endtask

    function automatic void random_calib();
        foreach (next_calib[i])
            next_calib[i] = COEFF_W'($urandom);
    endfunction

    // Offer one sample and hold it until the block takes it
    task automatic send_sample(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {raw_t, raw_p};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_sample(raw_p, raw_t);
    endtask

    // Random samples: mostly near the reference temperature, where the
    // correction branches live, the rest across the whole raw range
    task automatic run_random(int count);
        logic [RAW_W-1:0] p, t;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(0, 3))
                0: t = RAW_W'($urandom);
                1: t = raw_near_ref(int'($urandom_range(0, 4000)) - 2000);
                2: t = raw_near_ref(int'($urandom_range(0, 600000)) - 300000);
                default: t = raw_near_ref(int'($urandom_range(0, 6000000)) - 3000000);
            endcase
            if ($urandom_range(0, 99) < 8)
                p = $urandom_range(0, 1) ? RAW_MAX : '0;
            else
                p = RAW_W'($urandom);
            send_sample(p, t);
        end
    endtask

    // Stop offering and let every outstanding result come back
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Calibration as left by reset
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        run_random(20);
        drain();

        // Typical factory calibration, with the branch edges hit directly
        next_calib[REG_SENS_BASE]   = 16'd40127;
        next_calib[REG_OFFSET_BASE] = 16'd36924;
        next_calib[REG_SENS_TEMP]   = 16'd23317;
        next_calib[REG_OFFSET_TEMP] = 16'd23282;
        next_calib[REG_REF_TEMP]    = 16'd33464;
        next_calib[REG_TEMP_SLOPE]  = 16'd28312;
        load_calib(1'b1);
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample('0, RAW_MAX);
        send_sample(RAW_MAX, '0);
        send_sample(24'd6465444, raw_near_ref(0));         // exactly 20.00 C
        send_sample(24'd6465444, raw_near_ref(-1));        // just below 20.00 C
        send_sample(24'd6465444, raw_near_ref(1));
        send_sample(24'd6465444, raw_near_ref(-1037020));  // exactly -15.00 C
        send_sample(24'd6465444, raw_near_ref(-1037021));  // just below -15.00 C
        send_sample(RAW_MAX, raw_near_ref(-3000000));      // deep cold
        send_sample('0, raw_near_ref(-3000000));
        send_sample(24'h555555, 24'hAAAAAA);
        send_sample(24'hAAAAAA, 24'h555555);
        run_random(60);
        long_hold_req = 1'b1;
        run_random(90);
        drain();

        // All words at their maximum
        foreach (next_calib[i]) next_calib[i] = COEFF_MAX;
        load_calib(1'b1);
        send_sample('0, '0);
        send_sample(RAW_MAX, RAW_MAX);
        send_sample('0, RAW_MAX);
        send_sample(RAW_MAX, '0);
        send_sample(RAW_MAX, raw_near_ref(-1));
        run_random(100);
        drain();

        // Zero reference, steepest slope: always warm
        foreach (next_calib[i]) next_calib[i] = COEFF_MAX;
        next_calib[REG_REF_TEMP] = '0;
        load_calib(1'b0);
        run_random(60);
        drain();

        // Zero gains, highest reference: cold whenever the raw temperature is below it
        foreach (next_calib[i]) next_calib[i] = '0;
        next_calib[REG_REF_TEMP]   = COEFF_MAX;
        next_calib[REG_TEMP_SLOPE] = COEFF_MAX;
        load_calib(1'b0);
        run_random(60);
        drain();

        // Back-to-back stretch with no idling
        random_calib();
        load_calib(1'b1);
        steady = 1'b1;
        run_random(100);
        drain();
        steady = 1'b0;

        // Random calibrations, one with another long output hold
        for (int ph = 0; ph < 3; ph++)
        begin
            random_calib();
            load_calib(1'b1);
            run_random(30);
            if (ph == 1)
                long_hold_req = 1'b1;
            run_random(50);
            drain();
        end

        $display("Checked %0d compensated samples over %0d calibration settings.",
                 sb.checked, sb.settings);
        $display("Cold correction taken %0d times, very cold term %0d times.",
                 sb.cold_hits, sb.very_cold_hits);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: baro_pressure_temp_compensation_core.f
+incdir+hw/rtl
hw/rtl/bptc_pkg.sv
hw/rtl/baro_pressure_temp_compensation_core.sv
tb/baro_pressure_temp_compensation_core_tb.sv
